// ----- src/trbs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trbs_pkg: shared types and constants for the typed range binary search
// Table geometry, pointer widths, item mode codes, controller states and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package trbs_pkg;

  localparam int TableDepth = 1024;
  localparam int IdxW       = $clog2(TableDepth);
  localparam int RightW     = IdxW + 1;       // signed right bound, -1 = empty
  localparam int PtrW       = IdxW + 2;       // signed working pointers
  localparam int TypeW      = 8;
  localparam int ValW       = 32;

  localparam logic signed [PtrW-1:0] PtrOne = 1;

  localparam logic ModeWrite  = 1'b0;
  localparam logic ModeSearch = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StLoop,
    StProbeRd,
    StProbeChk,
    StFinRd,
    StFinChk,
    StDone
  } trbs_state_e;

  typedef struct packed {
    logic write_entry;
    logic load_search;
    logic start_probe;
    logic mem_read;
    logic probe_check;
    logic final_init;
    logic final_check;
    logic load_out;
  } trbs_cmd_t;

  typedef struct packed {
    logic lo_le_hi;       // window still open
    logic type_hit;       // read entry carries the search type
    logic probe_more;     // scan pointer minus one still >= lo
    logic matched;        // some typed entry was probed
    logic right_gt_left;  // final scan has slots to visit
    logic final_more;     // scan pointer minus one still > left
  } trbs_stat_t;

endpackage
`default_nettype wire

// ----- src/typed_range_binary_search.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// typed_range_binary_search: typed binary search over a sorted entry table
// Loads (type, value) entries and searches a window for the rightmost entry
// of a type enclosing an address.
//
//  Channel  Dir  tuser       tdata
//  s_axis   in   mode        write fields and search fields
//  m_axis   out  -           found_left, found_right, any_match
//
//  A write is done in idle. A search goes through setup, a loop state per
//  probe with a read state and a compare state per scanned slot, a read
//  and a compare per slot of the final scan, and the hand-off; the single
//  read port of the entry memory makes each slot a read then a compare.
//  Reset clears only the controller; the table is undefined until written.
//  A result waits in the output register; a new item is taken meanwhile.
// ----------------------------------------------------------------------------
module typed_range_binary_search (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // [9:0] entry_index, [17:10] entry_type, [49:18] entry_value,
  // [57:50] search_type, [89:58] search_addr, [99:90] start_left,
  // [110:100] start_right, [111] zero
  input  logic [111:0] s_axis_tdata_i,
  // [0] mode
  input  logic [0:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [9:0] found_left, [20:10] found_right, [21] any_match, [23:22] zero
  output logic [23:0]  m_axis_tdata_o
);
  import trbs_pkg::*;

  trbs_cmd_t  cmd;
  trbs_stat_t stat;

  logic [IdxW-1:0]          found_left;
  logic signed [RightW-1:0] found_right;
  logic                     any_match;

  trbs_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .mode_i    (s_axis_tuser_i[0]),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  trbs_dp u_dp (
    .clk_i         (clk_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .entry_index_i (s_axis_tdata_i[9:0]),
    .entry_type_i  (s_axis_tdata_i[17:10]),
    .entry_value_i (s_axis_tdata_i[49:18]),
    .search_type_i (s_axis_tdata_i[57:50]),
    .search_addr_i (s_axis_tdata_i[89:58]),
    .start_left_i  (s_axis_tdata_i[99:90]),
    .start_right_i ($signed(s_axis_tdata_i[110:100])),
    .found_left_o  (found_left),
    .found_right_o (found_right),
    .any_match_o   (any_match)
  );

  assign m_axis_tdata_o = {2'b00, any_match, found_right, found_left};

  // at most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("trbs: more than one datapath command active");

  // a table write never produces a result
  a_write_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == ModeWrite)
     && !m_axis_tvalid_o) |=> !m_axis_tvalid_o)
    else $error("trbs: result appeared after a table write");

  // no match means right bound is left minus one
  a_nomatch_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tdata_o[21]) |->
    (m_axis_tdata_o[20:10] == (RightW'({1'b0, m_axis_tdata_o[9:0]}) - RightW'(1))))
    else $error("trbs: unmatched result with inconsistent bounds");

endmodule
`default_nettype wire

// ----- src/trbs_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trbs_dp: datapath of the typed range binary search
// Entry memory, window/bound registers, scan pointer, comparators and the
// result register. Steered by commands from trbs_ctrl.
// ----------------------------------------------------------------------------
module trbs_dp (
  input  logic                              clk_i,
  input  trbs_pkg::trbs_cmd_t               cmd_i,
  output trbs_pkg::trbs_stat_t              stat_o,
  input  logic [trbs_pkg::IdxW-1:0]         entry_index_i,
  input  logic [trbs_pkg::TypeW-1:0]        entry_type_i,
  input  logic [trbs_pkg::ValW-1:0]         entry_value_i,
  input  logic [trbs_pkg::TypeW-1:0]        search_type_i,
  input  logic [trbs_pkg::ValW-1:0]         search_addr_i,
  input  logic [trbs_pkg::IdxW-1:0]         start_left_i,
  input  logic signed [trbs_pkg::RightW-1:0] start_right_i,
  output logic [trbs_pkg::IdxW-1:0]         found_left_o,
  output logic signed [trbs_pkg::RightW-1:0] found_right_o,
  output logic                              any_match_o
);
  import trbs_pkg::*;

  logic [TypeW+ValW-1:0]   mem_q [TableDepth];
  logic [TypeW-1:0]        rd_type_q;
  logic [ValW-1:0]         rd_val_q;

  logic signed [PtrW-1:0]  lo_q, hi_q, left_q, right_q, mid_q, scan_q;
  logic [ValW-1:0]         addr_q;
  logic [TypeW-1:0]        stype_q;
  logic                    matched_q;

  logic [IdxW-1:0]         found_left_q;
  logic signed [RightW-1:0] found_right_q;
  logic                    any_match_q;

  logic signed [PtrW-1:0]  sum_c, mid_c, scan_dec_c;

  assign sum_c      = lo_q + hi_q;         // both in window, no overflow
  assign mid_c      = sum_c >>> 1;         // sum is non-negative when lo <= hi
  assign scan_dec_c = scan_q - PtrOne;

  assign stat_o.lo_le_hi      = (lo_q <= hi_q);
  assign stat_o.type_hit      = (rd_type_q == stype_q);
  assign stat_o.probe_more    = (scan_dec_c >= lo_q);
  assign stat_o.matched       = matched_q;
  assign stat_o.right_gt_left = (right_q > left_q);
  assign stat_o.final_more    = (scan_dec_c > left_q);

  // entry memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.write_entry) begin
      mem_q[entry_index_i] <= {entry_type_i, entry_value_i};
    end
    if (cmd_i.mem_read) begin
      {rd_type_q, rd_val_q} <= mem_q[scan_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_search) begin
      lo_q      <= $signed({{(PtrW-IdxW){1'b0}}, start_left_i});
      left_q    <= $signed({{(PtrW-IdxW){1'b0}}, start_left_i});
      hi_q      <= {{(PtrW-RightW){start_right_i[RightW-1]}}, start_right_i};
      right_q   <= {{(PtrW-RightW){start_right_i[RightW-1]}}, start_right_i};
      addr_q    <= search_addr_i;
      stype_q   <= search_type_i;
      matched_q <= 1'b0;
    end

    if (cmd_i.start_probe) begin
      mid_q  <= mid_c;
      scan_q <= mid_c;
    end

    if (cmd_i.probe_check) begin
      if (stat_o.type_hit) begin
        matched_q <= 1'b1;
        if (rd_val_q < addr_q) begin
          left_q <= scan_q;
          lo_q   <= mid_q + PtrOne;
        end else if (rd_val_q > addr_q) begin
          right_q <= scan_dec_c;
          hi_q    <= scan_dec_c;
        end else begin
          // exact hit: keep going for the next higher address
          left_q <= scan_q;
          lo_q   <= scan_q;
          addr_q <= addr_q + ValW'(1);
        end
      end else if (stat_o.probe_more) begin
        scan_q <= scan_dec_c;
      end else begin
        lo_q <= mid_q + PtrOne;
      end
    end

    if (cmd_i.final_init) begin
      if (!matched_q) begin
        right_q <= left_q - PtrOne;
      end else begin
        scan_q <= right_q;
        if (!stat_o.right_gt_left) begin
          left_q <= right_q;
        end
      end
    end

    if (cmd_i.final_check) begin
      if (stat_o.type_hit) begin
        left_q <= scan_q;
      end else if (stat_o.final_more) begin
        scan_q <= scan_dec_c;
      end else begin
        left_q <= scan_dec_c;
      end
    end

    if (cmd_i.load_out) begin
      found_left_q  <= left_q[IdxW-1:0];
      found_right_q <= right_q[RightW-1:0];
      any_match_q   <= matched_q;
    end
  end

  assign found_left_o  = found_left_q;
  assign found_right_o = found_right_q;
  assign any_match_o   = any_match_q;

endmodule
`default_nettype wire

// ----- src/trbs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// trbs_ctrl: controller of the typed range binary search
// Sequences table writes, probes, the final downward scan and the result
// hand-off; owns the stream handshakes.
// ----------------------------------------------------------------------------
module trbs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic                 mode_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  input  trbs_pkg::trbs_stat_t stat_i,
  output trbs_pkg::trbs_cmd_t  cmd_o
);
  import trbs_pkg::*;

  trbs_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        s_acc;
  logic        out_free;

  assign s_ready_o = (state_q == StIdle);
  assign s_acc     = s_valid_i && s_ready_o;
  assign out_free  = !out_valid_q || m_ready_i;
  assign m_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (s_acc && (mode_i == ModeSearch)) begin
          state_d = StLoop;
        end
      end
      StLoop: begin
        if (stat_i.lo_le_hi) begin
          state_d = StProbeRd;
        end else if (stat_i.matched && stat_i.right_gt_left) begin
          state_d = StFinRd;
        end else begin
          state_d = StDone;
        end
      end
      StProbeRd: state_d = StProbeChk;
      StProbeChk: begin
        if (stat_i.type_hit || !stat_i.probe_more) begin
          state_d = StLoop;
        end else begin
          state_d = StProbeRd;
        end
      end
      StFinRd: state_d = StFinChk;
      StFinChk: begin
        if (stat_i.type_hit || !stat_i.final_more) begin
          state_d = StDone;
        end else begin
          state_d = StFinRd;
        end
      end
      StDone: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    case (state_q)
      StIdle: begin
        cmd_o.write_entry = s_acc && (mode_i == ModeWrite);
        cmd_o.load_search = s_acc && (mode_i == ModeSearch);
      end
      StLoop: begin
        cmd_o.start_probe = stat_i.lo_le_hi;
        cmd_o.final_init  = !stat_i.lo_le_hi;
      end
      StProbeRd:  cmd_o.mem_read    = 1'b1;
      StProbeChk: cmd_o.probe_check = 1'b1;
      StFinRd:    cmd_o.mem_read    = 1'b1;
      StFinChk:   cmd_o.final_check = 1'b1;
      StDone:     cmd_o.load_out    = out_free;
      default:    cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

// ----- test/tb_typed_range_binary_search.sv -----
// ----------------------------------------------------------------------------
// tb_typed_range_binary_search: self-checking bench for the typed range search
// Loads sorted runs of typed entries, searches empty windows and windows in
// written slots only, and checks every result against a cycle-free model of
// the search. The sender and receiver idle at random, in several phases.
// ----------------------------------------------------------------------------
module tb_typed_range_binary_search;
  import trbs_pkg::*;

  localparam int ClkPeriod   = 10;
  localparam int ResetCycles = 8;
  localparam int SettleWait  = 20;
  localparam int QuietLimit  = 200000;
  localparam int PhaseItems  = 100;
  localparam int MaxReports  = 10;

  typedef struct {
    logic                     mode;
    logic [IdxW-1:0]          entry_index;
    logic [TypeW-1:0]         entry_type;
    logic [ValW-1:0]          entry_value;
    logic [TypeW-1:0]         search_type;
    logic [ValW-1:0]          search_addr;
    logic [IdxW-1:0]          start_left;
    logic signed [RightW-1:0] start_right;
  } table_op_t;

  typedef struct {
    logic [IdxW-1:0]          found_left;
    logic signed [RightW-1:0] found_right;
    logic                     any_match;
  } search_hit_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [111:0] s_data = '0;
  logic [0:0]   s_user = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [23:0]  m_data;

  typed_range_binary_search u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  // model copy of the table, updated as write transactions are accepted
  logic [TypeW-1:0] tbl_type [TableDepth];
  logic [ValW-1:0]  tbl_val  [TableDepth];
  // stimulus-side view of the table, runs ahead of acceptance
  logic [TypeW-1:0] plan_type    [TableDepth];
  logic [ValW-1:0]  plan_val     [TableDepth];
  int               region_base[$];
  int               region_len[$];

  table_op_t   pending_ops[$];
  table_op_t   cur_op;
  search_hit_t expected_hits[$];
  int          fail_count = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;

  initial begin
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  function automatic bit typed_slot(input int idx, input logic [TypeW-1:0] t);
    if (idx < 0 || idx >= TableDepth) return 1'b0;
    return tbl_type[idx] == t;
  endfunction

  function automatic search_hit_t run_typed_search(input table_op_t op);
    int            lo, hi, lft, rgt, mid, m, k;
    logic [ValW-1:0] addr, v;
    bit            hit_any;
    search_hit_t   r;
    lft     = int'(op.start_left);
    rgt     = int'(op.start_right);
    addr    = op.search_addr;
    lo      = lft;
    hi      = rgt;
    hit_any = 1'b0;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      m = mid;
      while (m >= lo && !typed_slot(m, op.search_type)) m--;
      if (m < lo) begin
        lo = mid + 1;
      end else begin
        hit_any = 1'b1;
        v = tbl_val[m];
        if (v < addr) begin
          lft = m;
          lo = mid + 1;
        end else if (v > addr) begin
          rgt = m - 1;
          hi = m - 1;
        end else begin
          // exact hit: keep looking for the next address up
          lft = m;
          lo = m;
          addr = addr + ValW'(1);
        end
      end
    end
    if (!hit_any) begin
      rgt = lft - 1;
    end else begin
      k = rgt;
      while (k > lft && !typed_slot(k, op.search_type)) k--;
      lft = k;
    end
    r.found_left  = lft[IdxW-1:0];
    r.found_right = rgt[RightW-1:0];
    r.any_match   = hit_any;
    return r;
  endfunction

  // unused fields are random so that every tdata bit but the zero top bit toggles
  function automatic table_op_t noise_op();
    table_op_t op;
    op.mode        = ModeWrite;
    op.entry_index = IdxW'($urandom);
    op.entry_type  = TypeW'($urandom);
    op.entry_value = $urandom;
    op.search_type = TypeW'($urandom);
    op.search_addr = $urandom;
    op.start_left  = IdxW'($urandom);
    op.start_right = RightW'($urandom);
    return op;
  endfunction

  task automatic queue_write(input int idx, input logic [TypeW-1:0] t,
                             input logic [ValW-1:0] v);
    table_op_t op;
    op = noise_op();
    op.mode        = ModeWrite;
    op.entry_index = IdxW'(idx);
    op.entry_type  = t;
    op.entry_value = v;
    plan_type[idx] = t;
    plan_val[idx]  = v;
    pending_ops.push_back(op);
  endtask

  task automatic queue_search(input logic [TypeW-1:0] t, input logic [ValW-1:0] a,
                              input int lft, input int rgt);
    table_op_t op;
    op = noise_op();
    op.mode        = ModeSearch;
    op.search_type = t;
    op.search_addr = a;
    op.start_left  = IdxW'(lft);
    op.start_right = RightW'(rgt);
    pending_ops.push_back(op);
  endtask

  // a run of entries sorted by value, drawn from a few types
  task automatic queue_sorted_run(input int base, input int len);
    int               i, ntypes, step_max;
    logic [TypeW-1:0] tset [3];
    logic [32:0]      v;
    ntypes = $urandom_range(1, 3);
    for (i = 0; i < 3; i++) tset[i] = TypeW'($urandom);
    case ($urandom_range(0, 3))
      0: v = '0;
      1: v = {1'b0, $urandom};
      2: v = 33'hFFFF_FFFF - 33'($urandom_range(0, 64));
      default: v = 33'($urandom_range(0, 1000));
    endcase
    case ($urandom_range(0, 3))
      0: step_max = 1;
      1: step_max = 4;
      2: step_max = 1000;
      default: step_max = 1 << 26;
    endcase
    for (i = 0; i < len; i++) begin
      queue_write(base + i, tset[$urandom_range(0, ntypes - 1)], v[ValW-1:0]);
      v = v + 33'($urandom_range(0, step_max));
      if (v > 33'hFFFF_FFFF) v = 33'hFFFF_FFFF;
    end
    region_base.push_back(base);
    region_len.push_back(len);
  endtask

  // window inside a written run, so no never-written slot gets read
  task automatic queue_window_search();
    int              r, lft, rgt, slot;
    logic [TypeW-1:0] t;
    logic [ValW-1:0]  a;
    r    = $urandom_range(0, region_base.size() - 1);
    lft  = region_base[r] + $urandom_range(0, region_len[r] - 1);
    rgt  = lft + $urandom_range(0, region_base[r] + region_len[r] - 1 - lft);
    slot = lft + $urandom_range(0, rgt - lft);
    t = ($urandom_range(0, 9) < 8) ? plan_type[slot] : 8'($urandom);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: a = plan_val[slot];
      4: a = plan_val[slot] + ValW'(1);
      5: a = plan_val[slot] - ValW'(1);
      6: a = '0;
      7: a = '1;
      default: a = $urandom;
    endcase
    queue_search(t, a, lft, rgt);
  endtask

  task automatic queue_random_phase();
    int count, len, base, pick, lft;
    count = 0;
    while (count < PhaseItems) begin
      pick = $urandom_range(0, 99);
      if (region_base.size() == 0 || pick < 20) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 200)
                                           : $urandom_range(1, 24);
        base = $urandom_range(0, TableDepth - 1);
        if (base + len > TableDepth) len = TableDepth - base;
        queue_sorted_run(base, len);
        count += len;
      end else if (pick < 25) begin
        // out-of-order value dropped into an already written slot
        base = region_base[$urandom_range(0, region_base.size() - 1)];
        queue_write(base, plan_type[base], $urandom);
        count++;
      end else if (pick < 31) begin
        lft = $urandom_range(0, TableDepth - 1);
        queue_search(TypeW'($urandom), $urandom, lft,
                     int'($urandom_range(0, lft)) - 1);
        count++;
      end else begin
        queue_window_search();
        count++;
      end
    end
  endtask

  task automatic queue_directed();
    queue_write(0, 8'hA5, 32'hFFFF_FFFF);
    queue_write(1, 8'h00, 32'h0000_0000);
    queue_write(2, 8'h5A, 32'h0000_0010);
    queue_write(3, 8'h00, 32'h0000_0010);
    queue_write(4, 8'h5A, 32'h0000_0020);
    queue_write(5, 8'h00, 32'h7FFF_FFFF);
    queue_write(6, 8'h00, 32'hFFFF_FFFF);
    queue_write(1022, 8'h00, 32'h1234_5678);
    queue_write(1023, 8'hFF, 32'h8000_0000);
    // empty windows, then typed searches in the written run
    queue_search(8'h00, 32'h0, 0, -1);
    queue_search(8'hFF, 32'hFFFF_FFFF, 1023, -1);
    queue_search(8'h5A, 32'h10, 512, 511);
    queue_search(8'h00, 32'h10, 1, 6);
    queue_search(8'h00, 32'h0, 1, 6);
    queue_search(8'h00, 32'h15, 1, 6);
    // hit at the top address wraps to zero
    queue_search(8'h00, 32'hFFFF_FFFF, 1, 6);
    queue_search(8'h77, 32'h10, 1, 6);
    queue_search(8'h5A, 32'h20, 0, 6);
    queue_search(8'hFF, 32'h8000_0000, 1022, 1023);
    queue_search(8'h00, 32'hFFFF_FFFF, 1022, 1023);
    // wrap then overshoot leaves the left bound at minus one
    queue_search(8'hA5, 32'hFFFF_FFFF, 0, 0);
    region_base.push_back(0);
    region_len.push_back(7);
    region_base.push_back(1022);
    region_len.push_back(2);
  endtask

  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_valid || expected_hits.size() != 0)
      @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MaxReports) $display("%s", msg);
  endtask

  // driver: predicts on acceptance, then offers the next item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid <= 1'b0;
      s_data  <= '0;
      s_user  <= '0;
    end else begin
      if (s_valid && s_ready) begin
        if (cur_op.mode == ModeWrite) begin
          tbl_type[cur_op.entry_index] = cur_op.entry_type;
          tbl_val[cur_op.entry_index]  = cur_op.entry_value;
        end else begin
          expected_hits.push_back(run_typed_search(cur_op));
        end
      end
      if (!s_valid || s_ready) begin
        if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_op = pending_ops.pop_front();
          s_valid <= 1'b1;
          s_data  <= {1'b0, cur_op.start_right, cur_op.start_left, cur_op.search_addr,
                      cur_op.search_type, cur_op.entry_value, cur_op.entry_type,
                      cur_op.entry_index};
          s_user  <= cur_op.mode;
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result transaction against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin
    search_hit_t want;
    search_hit_t got;
    if (!rst_ni) begin
      m_ready <= 1'b0;
    end else begin
      if (m_valid && m_ready) begin
        got.found_left  = m_data[9:0];
        got.found_right = m_data[20:10];
        got.any_match   = m_data[21];
        if (expected_hits.size() == 0) begin
          note_failure($sformatf("unexpected result left=%0d right=%0d match=%0b",
                                 got.found_left, got.found_right, got.any_match));
        end else begin
          want = expected_hits.pop_front();
          if (got.found_left !== want.found_left || got.found_right !== want.found_right
              || got.any_match !== want.any_match)
            note_failure($sformatf(
              "result mismatch: exp left=%0d right=%0d match=%0b, got left=%0d right=%0d match=%0b",
              want.found_left, want.found_right, want.any_match,
              got.found_left, got.found_right, got.any_match));
        end
      end
      m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready) ||
          (pending_ops.size() == 0 && !s_valid && expected_hits.size() == 0))
        quiet = 0;
      else
        quiet++;
    end
    $display("typed_range_binary_search verification failed");
    $finish;
  end

  initial begin
    int send_pcts [4];
    int recv_pcts [4];
    int ph;
    send_pcts = '{0, 49, 0, 26};
    recv_pcts = '{0, 0, 49, 26};
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    queue_directed();
    wait_drained();
    for (ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pcts[ph];
      recv_stall_pct = recv_pcts[ph];
      queue_random_phase();
      // sender holds off until every pending result is back
      wait_drained();
    end
    if (expected_hits.size() != 0)
      note_failure($sformatf("%0d results never arrived", expected_hits.size()));
    if (fail_count == 0) begin
      $display("typed_range_binary_search verification clean");
    end else begin
      $display("typed_range_binary_search verification failed");
    end
    $finish;
  end

endmodule
